FILE: rtl/vpcd_pkg.sv
// ----------------------------------------------------------------------------
// vpcd_pkg
// Shared types and constants of the vector picture command decoder: command
// codes, palette modes, the queue entry and the register set.
// ----------------------------------------------------------------------------
package vpcd_pkg;

  // command kinds as they appear on the result channel
  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;
  localparam logic [1:0] KIND_PIC  = 2'd3;

  // script opcodes
  localparam logic [7:0] OP_MOVE = 8'hC0;
  localparam logic [7:0] OP_FILL = 8'hC1;
  localparam logic [7:0] OP_PIC  = 8'hFF;

  // palette modes
  localparam logic [1:0] PAL_ZX  = 2'd0;
  localparam logic [1:0] PAL_C64 = 2'd1;
  localparam logic [1:0] PAL_VGA = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PALETTE_MODE  = 2'd0;
  localparam logic [1:0] REG_PICTURE_LIMIT = 2'd1;
  localparam logic [1:0] REG_ERROR_LIMIT   = 2'd2;

  // register reset values
  localparam logic [1:0] PALETTE_MODE_RST  = 2'd0;
  localparam logic [7:0] PICTURE_LIMIT_RST = 8'd31;
  localparam logic [7:0] ERROR_LIMIT_RST   = 8'd100;

  // range checks
  localparam logic [7:0] X_MAX      = 8'd254;
  localparam logic [7:0] Y_MIN      = 8'd96;
  localparam logic [7:0] Y_MAX      = 8'd191;
  localparam logic [7:0] COLOUR_MAX = 8'd15;

  localparam logic [2:0] LINE_ON_BLACK  = 3'd7;
  localparam logic [4:0] COLOUR_INVALID = 5'd16;
  localparam logic [8:0] CNT_MAX        = 9'd511;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] C64_MAP [16] = '{
    3'd0, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd7, 3'd1,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
  };

  // one completed command as classified by the front
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;        // x byte, or background colour for a new picture
    logic [7:0] held_y;
    logic [7:0] held_colour;
  } vpcd_cmd_t;

  typedef struct packed {
    logic [1:0] palette_mode;
    logic [7:0] picture_limit;
    logic [7:0] error_limit;
  } vpcd_cfg_t;

  function automatic logic [4:0] map_colour(input logic [7:0] raw, input logic [1:0] mode);
    logic [4:0] res;
    if (raw > COLOUR_MAX) begin
      res = COLOUR_INVALID;
    end else if (mode == PAL_C64) begin
      res = {2'b00, C64_MAP[raw[3:0]]};
    end else begin
      res = {1'b0, raw[3:0]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/vpcd_front.sv
// ----------------------------------------------------------------------------
// vpcd_front
// Byte parser: tracks where in a command the script stands and emits one
// queue entry for every command that completes.
// ----------------------------------------------------------------------------
module vpcd_front
  import vpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output logic       push,
  output vpcd_cmd_t  cmd
);

  typedef enum logic [7:0] {
    PH_OP     = 8'b0000_0001,
    PH_MOVE_Y = 8'b0000_0010,
    PH_MOVE_X = 8'b0000_0100,
    PH_FILL_C = 8'b0000_1000,
    PH_FILL_Y = 8'b0001_0000,
    PH_FILL_X = 8'b0010_0000,
    PH_PIC_C  = 8'b0100_0000,
    PH_DRAW_X = 8'b1000_0000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_y_r, held_y_nxt;
  logic [7:0] held_colour_r, held_colour_nxt;
  logic       done;
  logic [1:0] kind;

  always_comb begin
    phase_nxt       = phase_r;
    held_y_nxt      = held_y_r;
    held_colour_nxt = held_colour_r;
    done            = 1'b0;
    kind            = KIND_MOVE;
    case (phase_r)
      PH_OP: begin
        if (data_byte == OP_MOVE) begin
          phase_nxt = PH_MOVE_Y;
        end else if (data_byte == OP_FILL) begin
          phase_nxt = PH_FILL_C;
        end else if (data_byte == OP_PIC) begin
          phase_nxt = PH_PIC_C;
        end else begin
          held_y_nxt = data_byte;
          phase_nxt  = PH_DRAW_X;
        end
      end
      PH_MOVE_Y: begin
        held_y_nxt = data_byte;
        phase_nxt  = PH_MOVE_X;
      end
      PH_FILL_C: begin
        held_colour_nxt = data_byte;
        phase_nxt       = PH_FILL_Y;
      end
      PH_FILL_Y: begin
        held_y_nxt = data_byte;
        phase_nxt  = PH_FILL_X;
      end
      PH_MOVE_X: begin
        done      = 1'b1;
        kind      = KIND_MOVE;
        phase_nxt = PH_OP;
      end
      PH_FILL_X: begin
        done      = 1'b1;
        kind      = KIND_FILL;
        phase_nxt = PH_OP;
      end
      PH_PIC_C: begin
        done      = 1'b1;
        kind      = KIND_PIC;
        phase_nxt = PH_OP;
      end
      PH_DRAW_X: begin
        done      = 1'b1;
        kind      = KIND_DRAW;
        phase_nxt = PH_OP;
      end
      default: begin
        phase_nxt = PH_OP;
      end
    endcase
  end

  assign push             = accept && done;
  assign cmd.kind         = kind;
  assign cmd.data         = data_byte;
  assign cmd.held_y       = held_y_r;
  assign cmd.held_colour  = held_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OP;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_y_r      <= held_y_nxt;
      held_colour_r <= held_colour_nxt;
    end
  end

endmodule

FILE: rtl/vpcd_queue.sv
// ----------------------------------------------------------------------------
// vpcd_queue
// Small command queue between the parser and the executing back end.
// ----------------------------------------------------------------------------
module vpcd_queue
  import vpcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  vpcd_cmd_t push_cmd,
  input  logic      pop,
  output logic      q_valid,
  output logic      q_full,
  output vpcd_cmd_t q_cmd
);

  vpcd_cmd_t            ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    count_r, count_nxt;
  logic                 do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_cmd   = ent_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/vpcd_back.sv
// ----------------------------------------------------------------------------
// vpcd_back
// Executes queued commands: pen and line colour, range checks, counters,
// halt decision and the registered result stage.
// ----------------------------------------------------------------------------
module vpcd_back
  import vpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  vpcd_cfg_t  cfg,
  input  logic       q_valid,
  input  vpcd_cmd_t  q_cmd,
  output logic       pop,
  output logic       halted,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_to_x,
  output logic [7:0] out_to_y,
  output logic [7:0] out_from_x,
  output logic [7:0] out_from_y,
  output logic [4:0] out_colour,
  output logic [4:0] out_border_colour,
  output logic [8:0] out_picture_number,
  output logic       out_x_error,
  output logic       out_y_error,
  output logic       out_colour_error,
  output logic       out_finished
);

  logic       halted_r, halted_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] pen_x_r, pen_x_nxt;
  logic [7:0] pen_y_r, pen_y_nxt;
  logic [2:0] line_colour_r, line_colour_nxt;
  logic [8:0] pic_cnt_r, pic_cnt_nxt;
  logic [8:0] err_cnt_r, err_cnt_nxt;
  logic       load;

  logic [1:0] res_kind;
  logic [7:0] res_to_x, res_to_y, res_from_x, res_from_y;
  logic [4:0] res_colour, res_border;
  logic       xe, ye, ce;
  logic [1:0] n_err;
  logic [9:0] err_sum;

  logic [1:0] kind_r;
  logic [7:0] to_x_r, to_y_r, from_x_r, from_y_r;
  logic [4:0] colour_r, border_r;
  logic [8:0] pic_num_r;
  logic       xe_r, ye_r, ce_r, fin_r;

  // once halted, queued commands are drained without a result
  assign pop  = q_valid && (halted_r || !out_valid_r || !out_stall);
  assign load = pop && !halted_r;

  always_comb begin
    pen_x_nxt       = pen_x_r;
    pen_y_nxt       = pen_y_r;
    line_colour_nxt = line_colour_r;
    pic_cnt_nxt     = pic_cnt_r;
    res_kind        = q_cmd.kind;
    res_to_x        = '0;
    res_to_y        = '0;
    res_from_x      = '0;
    res_from_y      = '0;
    res_colour      = '0;
    res_border      = '0;
    xe              = 1'b0;
    ye              = 1'b0;
    ce              = 1'b0;
    if (q_cmd.kind == KIND_PIC) begin
      ce              = q_cmd.data > COLOUR_MAX;
      line_colour_nxt = (q_cmd.data == 8'd0) ? LINE_ON_BLACK : 3'd0;
      if (pic_cnt_r != CNT_MAX) begin
        pic_cnt_nxt = pic_cnt_r + 1'b1;
      end
      res_colour = map_colour(q_cmd.data, cfg.palette_mode);
      res_border = map_colour({5'd0, line_colour_nxt}, cfg.palette_mode);
    end else begin
      xe       = q_cmd.data > X_MAX;
      ye       = (q_cmd.held_y < Y_MIN) || (q_cmd.held_y > Y_MAX);
      res_to_x = q_cmd.data;
      res_to_y = q_cmd.held_y;
      if (q_cmd.kind == KIND_FILL) begin
        ce         = q_cmd.held_colour > COLOUR_MAX;
        res_colour = map_colour(q_cmd.held_colour, cfg.palette_mode);
      end else begin
        if (q_cmd.kind == KIND_DRAW) begin
          res_from_x = pen_x_r;
          res_from_y = pen_y_r;
          res_colour = map_colour({5'd0, line_colour_r}, cfg.palette_mode);
        end
        pen_x_nxt = q_cmd.data;
        pen_y_nxt = q_cmd.held_y;
      end
    end
    n_err       = 2'(xe) + 2'(ye) + 2'(ce);
    err_sum     = {1'b0, err_cnt_r} + {8'd0, n_err};
    err_cnt_nxt = (err_sum > {1'b0, CNT_MAX}) ? CNT_MAX : err_sum[8:0];
    halted_nxt  = ({1'b0, pic_cnt_nxt} >= ({2'b00, cfg.picture_limit} + 10'd1)) ||
                  (err_cnt_nxt >= {1'b0, cfg.error_limit});
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      pen_x_r       <= '0;
      pen_y_r       <= '0;
      line_colour_r <= '0;
      pic_cnt_r     <= '0;
      err_cnt_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        halted_r      <= halted_nxt;
        pen_x_r       <= pen_x_nxt;
        pen_y_r       <= pen_y_nxt;
        line_colour_r <= line_colour_nxt;
        pic_cnt_r     <= pic_cnt_nxt;
        err_cnt_r     <= err_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r    <= res_kind;
      to_x_r    <= res_to_x;
      to_y_r    <= res_to_y;
      from_x_r  <= res_from_x;
      from_y_r  <= res_from_y;
      colour_r  <= res_colour;
      border_r  <= res_border;
      pic_num_r <= pic_cnt_nxt;
      xe_r      <= xe;
      ye_r      <= ye;
      ce_r      <= ce;
      fin_r     <= halted_nxt;
    end
  end

  assign halted             = halted_r;
  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_to_x           = to_x_r;
  assign out_to_y           = to_y_r;
  assign out_from_x         = from_x_r;
  assign out_from_y         = from_y_r;
  assign out_colour         = colour_r;
  assign out_border_colour  = border_r;
  assign out_picture_number = pic_num_r;
  assign out_x_error        = xe_r;
  assign out_y_error        = ye_r;
  assign out_colour_error   = ce_r;
  assign out_finished       = fin_r;

endmodule

FILE: rtl/vector_picture_command_decoder.sv
// ----------------------------------------------------------------------------
// vector_picture_command_decoder
// Decodes a byte-wide line-drawing picture script into move, draw, fill and
// new-picture commands, with range checks, counters and stop limits.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid/in_stall   | in_data_byte
//  out_    | output    | out_valid/out_stall | kind, to/from x y, colours,
//          |           |                     | picture_number, error flags
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One byte is accepted every cycle while in_stall is low. A command's result
//  is registered first in the two-entry command queue after its last byte,
//  then in the back end's output register.
//  in_stall rises only when the command queue is full, which happens only
//  while out_stall holds the output register.
//  Synchronous reset clears the control state, pen, line colour and counters;
//  cfg_ready is always high.
//
module vector_picture_command_decoder
  import vpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_to_x,
  output logic [7:0] out_to_y,
  output logic [7:0] out_from_x,
  output logic [7:0] out_from_y,
  output logic [4:0] out_colour,
  output logic [4:0] out_border_colour,
  output logic [8:0] out_picture_number,
  output logic       out_x_error,
  output logic       out_y_error,
  output logic       out_colour_error,
  output logic       out_finished,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  vpcd_cfg_t cfg_r;
  vpcd_cmd_t push_cmd, q_cmd;
  logic      in_accept, push, pop, q_valid, q_full, halted;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.palette_mode  <= PALETTE_MODE_RST;
      cfg_r.picture_limit <= PICTURE_LIMIT_RST;
      cfg_r.error_limit   <= ERROR_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PALETTE_MODE:  cfg_r.palette_mode  <= cfg_data[1:0];
        REG_PICTURE_LIMIT: cfg_r.picture_limit <= cfg_data;
        REG_ERROR_LIMIT:   cfg_r.error_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  vpcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .push      (push),
    .cmd       (push_cmd)
  );

  vpcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_cmd    (q_cmd)
  );

  vpcd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .pop                (pop),
    .halted             (halted),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_to_x           (out_to_x),
    .out_to_y           (out_to_y),
    .out_from_x         (out_from_x),
    .out_from_y         (out_from_y),
    .out_colour         (out_colour),
    .out_border_colour  (out_border_colour),
    .out_picture_number (out_picture_number),
    .out_x_error        (out_x_error),
    .out_y_error        (out_y_error),
    .out_colour_error   (out_colour_error),
    .out_finished       (out_finished)
  );

  // queue never takes an entry while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("command queue overflow");

  // after a halt no new result is produced
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (halted && !out_valid) |=> !out_valid)
    else $error("result produced after halt");

  // a result flagged finished means the back end has halted
  a_finish_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> halted)
    else $error("finished result without halt");

endmodule
